>>> rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants for the sequence-number reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

   // Field widths fixed by the request and response formats
   localparam int SEQ_W    = 8;
   localparam int KEY_W    = SEQ_W + 1;
   localparam int HANDLE_W = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 6;

   // Default number of buffer entries
   localparam int DEPTH_DEF = 32;

   // Request actions
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_POP    = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch request, build extended key
      logic compare;   // run all entry compares, register match vectors
      logic commit;    // update the entry row and load the response register
   } cmd_type;

endpackage

>>> rtl/srb_if.sv
// ----------------------------------------------------------------------------
// srb_req_if / srb_rsp_if
// Valid/ready channels carrying reorder buffer requests and responses.
// ----------------------------------------------------------------------------
interface srb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [srb_pkg::SEQ_W-1:0]     seq_in;
   logic [srb_pkg::SEQ_W-1:0]     last_ack;
   logic [srb_pkg::HANDLE_W-1:0]  handle_in;

   modport source (output valid, action, seq_in, last_ack, handle_in, input ready);
   modport sink   (input valid, action, seq_in, last_ack, handle_in, output ready);
endinterface

interface srb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [srb_pkg::STATUS_W-1:0]  status;
   logic                          pop_valid;
   logic [srb_pkg::SEQ_W-1:0]     seq_out;
   logic [srb_pkg::HANDLE_W-1:0]  handle_out;
   logic                          front_valid;
   logic [srb_pkg::SEQ_W-1:0]     front_seq;
   logic [srb_pkg::OCC_W-1:0]     occupancy;

   modport source (output valid, status, pop_valid, seq_out, handle_out, front_valid,
                   front_seq, occupancy, input ready);
   modport sink   (input valid, status, pop_valid, seq_out, handle_out, front_valid,
                   front_seq, occupancy, output ready);
endinterface

>>> rtl/srb_ctrl.sv
// ----------------------------------------------------------------------------
// srb_ctrl
// Request sequencer: accept, compare, commit, and response valid tracking.
// ----------------------------------------------------------------------------
module srb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srb_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_UPD  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_vld_ff, rsp_vld_in;
   logic      commit;

   // Commit only when the response register is free or being drained
   assign commit = (state_ff == S_UPD) && (!rsp_vld_ff || rsp_ready);

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.compare = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            if (commit) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Response valid: set on commit, cleared when taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
      if (commit) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_vld_ff;

endmodule

>>> rtl/srb_datapath.sv
// ----------------------------------------------------------------------------
// srb_datapath
// Sorted entry row with per-entry compare cells, count and response register.
// ----------------------------------------------------------------------------
module srb_datapath #(
   parameter int DEPTH = srb_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srb_pkg::cmd_type                cmd,
   input  logic                            req_action,
   input  logic [srb_pkg::SEQ_W-1:0]       req_seq_in,
   input  logic [srb_pkg::SEQ_W-1:0]       req_last_ack,
   input  logic [srb_pkg::HANDLE_W-1:0]    req_handle_in,
   output logic [srb_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_pop_valid,
   output logic [srb_pkg::SEQ_W-1:0]       rsp_seq_out,
   output logic [srb_pkg::HANDLE_W-1:0]    rsp_handle_out,
   output logic                            rsp_front_valid,
   output logic [srb_pkg::SEQ_W-1:0]       rsp_front_seq,
   output logic [srb_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // Latched request
   logic                          action_ff;
   logic [srb_pkg::KEY_W-1:0]     key_ff;
   logic [srb_pkg::HANDLE_W-1:0]  handle_ff;

   // Entry row, ascending by key; entries at or above count are unused
   logic [srb_pkg::KEY_W-1:0]     cell_key_ff    [DEPTH];
   logic [srb_pkg::HANDLE_W-1:0]  cell_handle_ff [DEPTH];
   logic [CNT_W-1:0]              count_ff, count_in;

   // Registered compare results
   logic [DEPTH-1:0]              eq_ff, gt_ff;
   logic [DEPTH-1:0]              eq_in, gt_in;

   logic                          dup, full, empty;
   logic                          ins_ok, pop_ok;
   logic [srb_pkg::KEY_W-1:0]     front_key;
   logic [srb_pkg::STATUS_W-1:0]  status_in;
   logic [CNT_W+srb_pkg::OCC_W-1:0] count_ext;

   // Request latch; wrapped numbers get the top key bit
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         key_ff    <= {(req_last_ack > req_seq_in), req_seq_in};
         handle_ff <= req_handle_in;
      end
   end

   // Compare cells: match, and "entry sorts after new key" (unused counts as after)
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         eq_in[i] = (CNT_W'(i) < count_ff) && (cell_key_ff[i] == key_ff);
         gt_in[i] = !(CNT_W'(i) < count_ff) || (cell_key_ff[i] > key_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         eq_ff <= eq_in;
         gt_ff <= gt_in;
      end
   end

   // Outcome of the request
   assign dup    = |eq_ff;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);
   assign ins_ok = (action_ff == srb_pkg::ACT_INSERT) && !dup && !full;
   assign pop_ok = (action_ff == srb_pkg::ACT_POP) && !empty;

   always_comb begin
      if (action_ff == srb_pkg::ACT_POP) begin
         status_in = empty ? srb_pkg::ST_EMPTY : srb_pkg::ST_OK;
      end else if (dup) begin
         status_in = srb_pkg::ST_DUP;
      end else if (full) begin
         status_in = srb_pkg::ST_FULL;
      end else begin
         status_in = srb_pkg::ST_OK;
      end
   end

   // Entry row update: insert shifts up from the slot, pop shifts everything down
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.commit && ins_ok && gt_ff[i]) begin
            if (i == 0) begin
               cell_key_ff[i]    <= key_ff;
               cell_handle_ff[i] <= handle_ff;
            end else if (!gt_ff[(i == 0) ? 0 : i-1]) begin
               cell_key_ff[i]    <= key_ff;
               cell_handle_ff[i] <= handle_ff;
            end else begin
               cell_key_ff[i]    <= cell_key_ff[(i == 0) ? 0 : i-1];
               cell_handle_ff[i] <= cell_handle_ff[(i == 0) ? 0 : i-1];
            end
         end else if (cmd.commit && pop_ok && (i < DEPTH-1)) begin
            cell_key_ff[i]    <= cell_key_ff[(i < DEPTH-1) ? i+1 : i];
            cell_handle_ff[i] <= cell_handle_ff[(i < DEPTH-1) ? i+1 : i];
         end
      end
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.commit && ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.commit && pop_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Front entry after this request
   always_comb begin
      if (ins_ok) begin
         front_key = gt_ff[0] ? key_ff : cell_key_ff[0];
      end else if (pop_ok) begin
         front_key = cell_key_ff[1];
      end else begin
         front_key = cell_key_ff[0];
      end
   end

   // Occupancy is reported modulo its field width
   assign count_ext = {{srb_pkg::OCC_W{1'b0}}, count_in};

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status      <= status_in;
         rsp_pop_valid   <= pop_ok;
         rsp_seq_out     <= pop_ok ? cell_key_ff[0][srb_pkg::SEQ_W-1:0] : '0;
         rsp_handle_out  <= pop_ok ? cell_handle_ff[0] : '0;
         rsp_front_valid <= (count_in != '0);
         rsp_front_seq   <= (count_in != '0) ? front_key[srb_pkg::SEQ_W-1:0] : '0;
         rsp_occupancy   <= count_ext[srb_pkg::OCC_W-1:0];
      end
   end

endmodule

>>> rtl/seqnum_reorder_buffer.sv
// ----------------------------------------------------------------------------
// seqnum_reorder_buffer
// Receive-side packet reorder buffer sorted by wrap-extended sequence number.
// ----------------------------------------------------------------------------
// Each request either inserts a packet (sequence number plus handle) in key
// order, where the key is the sequence number with 256 added when the last
// acknowledged number is greater, or pops the entry with the smallest key.
// Duplicates and inserts into a full buffer are rejected with a status code;
// every response also shows the front sequence number and the occupancy.
// A request moves from acceptance to response through an accept step, a
// compare step where every entry cell compares against the new key in
// parallel, and a commit step that shifts the entry row and loads the
// response register; no new request is taken until that commit. The
// response register lets the next request be accepted while a response
// still waits; a commit waits only if the previous response is not taken.
// The buffer is empty after reset and needs no clearing time.
// ----------------------------------------------------------------------------
module seqnum_reorder_buffer #(
   parameter int DEPTH = srb_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   srb_req_if.sink    req,
   srb_rsp_if.source  rsp
);

   srb_pkg::cmd_type cmd;

   // Request sequencer
   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // Entry row and response register
   srb_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req.action),
      .req_seq_in      (req.seq_in),
      .req_last_ack    (req.last_ack),
      .req_handle_in   (req.handle_in),
      .rsp_status      (rsp.status),
      .rsp_pop_valid   (rsp.pop_valid),
      .rsp_seq_out     (rsp.seq_out),
      .rsp_handle_out  (rsp.handle_out),
      .rsp_front_valid (rsp.front_valid),
      .rsp_front_seq   (rsp.front_seq),
      .rsp_occupancy   (rsp.occupancy)
   );

`ifndef SYNTHESIS
   // Only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while another is in flight");

   // A popped entry always reports ok
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.pop_valid) |-> (rsp.status == srb_pkg::ST_OK))
      else $error("pop returned an entry with a failing status");

   // Empty pop leaves an empty buffer
   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == srb_pkg::ST_EMPTY) |->
         (!rsp.front_valid && !rsp.pop_valid && rsp.front_seq == '0))
      else $error("empty pop shows a front entry");

   // A full buffer always has a front entry
   a_full_front: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == srb_pkg::ST_FULL) |-> rsp.front_valid)
      else $error("full status with no front entry");
`endif

endmodule

>>> bench/seqnum_reorder_buffer_test.sv
// ----------------------------------------------------------------------------
// seqnum_reorder_buffer_test
// Self-checking bench for the sequence-number reorder buffer.
// ----------------------------------------------------------------------------
// Requests go in through the request channel and are mirrored into a sorted
// shadow buffer kept here. The shadow gives the expected response for every
// accepted request. A separate process takes responses at random rates and
// checks them in order against the expected ones. The run starts with edge
// cases, then fills the buffer to full, then runs a long random mix,
// a long receiver hold-off and a gap-free burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module seqnum_reorder_buffer_test;
   import srb_pkg::*;

   localparam int BUF_DEPTH  = DEPTH_DEF;
   localparam int MAX_GAP    = 10;
   localparam int HOLD_LEN   = 300;
   localparam int MAX_REPORT = 40;
   localparam int LIMIT_NS   = 3_000_000;

   typedef struct packed {
      logic                action;
      logic [SEQ_W-1:0]    seq_in;
      logic [SEQ_W-1:0]    last_ack;
      logic [HANDLE_W-1:0] handle_in;
   } request_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                pop_valid;
      logic [SEQ_W-1:0]    seq_out;
      logic [HANDLE_W-1:0] handle_out;
      logic                front_valid;
      logic [SEQ_W-1:0]    front_seq;
      logic [OCC_W-1:0]    occupancy;
   } response_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srb_req_if req_ch ();
   srb_rsp_if rsp_ch ();

   seqnum_reorder_buffer #(.DEPTH(BUF_DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // Shadow copy of the sorted buffer
   logic [KEY_W-1:0]    shadow_key [BUF_DEPTH];
   logic [HANDLE_W-1:0] shadow_handle [BUF_DEPTH];
   int                  shadow_count = 0;

   response_t pending_rsp_q [$];

   int  error_count   = 0;
   int  sent_count    = 0;
   int  checked_count = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   bit  no_gaps       = 1'b0;
   int  rsp_hold_len  = 0;

   // Apply one request to the shadow buffer and build its response
   function automatic response_t apply_request(input request_t r);
      response_t        res;
      logic [KEY_W-1:0] key;
      int               pos;
      int               i;
      bit               dup;
      res = '0;
      if (r.action == ACT_INSERT) begin
         key = (r.last_ack > r.seq_in) ? {1'b1, r.seq_in} : {1'b0, r.seq_in};
         dup = 1'b0;
         for (i = 0; i < shadow_count; i++)
            if (shadow_key[i] == key) dup = 1'b1;
         if (dup) begin
            res.status = ST_DUP;
         end else if (shadow_count >= BUF_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_key[pos] < key) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_key[i]    = shadow_key[i-1];
               shadow_handle[i] = shadow_handle[i-1];
            end
            shadow_key[pos]    = key;
            shadow_handle[pos] = r.handle_in;
            shadow_count++;
            res.status = ST_OK;
         end
      end else if (shadow_count == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.status     = ST_OK;
         res.pop_valid  = 1'b1;
         res.seq_out    = shadow_key[0][SEQ_W-1:0];
         res.handle_out = shadow_handle[0];
         for (i = 1; i < shadow_count; i++) begin
            shadow_key[i-1]    = shadow_key[i];
            shadow_handle[i-1] = shadow_handle[i];
         end
         shadow_count--;
      end
      if (shadow_count > 0) begin
         res.front_valid = 1'b1;
         res.front_seq   = shadow_key[0][SEQ_W-1:0];
      end
      res.occupancy = OCC_W'(shadow_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_REPORT)
         $display("%0t ERROR response %0d %s: got %0d, expected %0d",
                  $realtime, checked_count, what, got, want);
      error_count++;
   endtask

   // Offer one request after a random gap and wait for acceptance
   task automatic send_request(input logic act, input logic [SEQ_W-1:0] seq,
                               input logic [SEQ_W-1:0] ack,
                               input logic [HANDLE_W-1:0] handle);
      request_t  r;
      response_t want;
      int        gap;
      r   = '{action: act, seq_in: seq, last_ack: ack, handle_in: handle};
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= r.action;
      req_ch.seq_in    <= r.seq_in;
      req_ch.last_ack  <= r.last_ack;
      req_ch.handle_in <= r.handle_in;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      want = apply_request(r);
      pending_rsp_q.push_back(want);
      status_seen[want.status]++;
      sent_count++;
   endtask

   // Response side: random stalls, an occasional long hold, in-order check
   initial begin : rsp_checker
      int        stall;
      response_t got;
      response_t want;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            stall        = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         got = '{status: rsp_ch.status, pop_valid: rsp_ch.pop_valid,
                 seq_out: rsp_ch.seq_out, handle_out: rsp_ch.handle_out,
                 front_valid: rsp_ch.front_valid, front_seq: rsp_ch.front_seq,
                 occupancy: rsp_ch.occupancy};
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected response, status", int'(got.status), -1);
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", int'(got.status), int'(want.status));
            if (got.pop_valid !== want.pop_valid)
               report_mismatch("pop_valid", int'(got.pop_valid), int'(want.pop_valid));
            if (got.seq_out !== want.seq_out)
               report_mismatch("seq_out", int'(got.seq_out), int'(want.seq_out));
            if (got.handle_out !== want.handle_out)
               report_mismatch("handle_out", int'(got.handle_out), int'(want.handle_out));
            if (got.front_valid !== want.front_valid)
               report_mismatch("front_valid", int'(got.front_valid),
                               int'(want.front_valid));
            if (got.front_seq !== want.front_seq)
               report_mismatch("front_seq", int'(got.front_seq), int'(want.front_seq));
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", int'(got.occupancy), int'(want.occupancy));
         end
         checked_count++;
      end
   end

   // Edge cases: empty pop, extreme numbers, wrap keys, duplicates
   task automatic test_edge_cases;
      send_request(ACT_POP,    8'd0,   8'd0,   8'd0);     // pop on empty buffer
      send_request(ACT_INSERT, 8'd0,   8'd0,   8'd0);     // key 0
      send_request(ACT_INSERT, 8'd255, 8'd0,   8'd255);   // key 255
      send_request(ACT_INSERT, 8'd0,   8'd255, 8'hA5);    // wrapped, key 256
      send_request(ACT_INSERT, 8'd254, 8'd255, 8'h5A);    // largest key, 510
      send_request(ACT_INSERT, 8'd0,   8'd1,   8'd1);     // same wrapped key
      send_request(ACT_INSERT, 8'd255, 8'd255, 8'd2);     // ack equal, no wrap, dup
      send_request(ACT_INSERT, 8'd10,  8'd10,  8'd3);     // ack equal, key 10
      send_request(ACT_INSERT, 8'd10,  8'd11,  8'd4);     // same seq wrapped, key 266
      send_request(ACT_INSERT, 8'd0,   8'd0,   8'd5);     // dup at the front
      repeat (6) send_request(ACT_POP, 8'd255, 8'd255, 8'd255);
      send_request(ACT_POP,    8'd255, 8'd255, 8'd255);   // empty again
   endtask

   // Fill to full, try inserts on a full buffer, then drain it
   task automatic test_fill_and_drain;
      logic [SEQ_W-1:0] seq;
      int               i;
      while (shadow_count < BUF_DEPTH)
         send_request(ACT_INSERT, SEQ_W'($urandom), SEQ_W'($urandom),
                      HANDLE_W'($urandom));
      for (i = 0; i < 4; i++)
         send_request(ACT_INSERT, SEQ_W'($urandom), SEQ_W'($urandom),
                      HANDLE_W'($urandom));
      // duplicate of the front key on a full buffer
      seq = shadow_key[0][SEQ_W-1:0];
      send_request(ACT_INSERT, seq, shadow_key[0][SEQ_W] ? 8'd255 : 8'd0,
                   HANDLE_W'($urandom));
      while (shadow_count > 0)
         send_request(ACT_POP, SEQ_W'($urandom), SEQ_W'($urandom), HANDLE_W'($urandom));
      send_request(ACT_POP, SEQ_W'($urandom), SEQ_W'($urandom), HANDLE_W'($urandom));
   endtask

   // Random mix in stretches, each one randomly fill-biased or drain-biased
   task automatic test_random_mix(input int n_items);
      int               i;
      int               insert_pct;
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] ack;
      insert_pct = 70;
      base       = SEQ_W'($urandom);
      for (i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            insert_pct = $urandom_range(0, 1) ? 75 : 30;
            base       = SEQ_W'($urandom);
         end
         if ($urandom_range(1, 100) <= insert_pct) begin
            // narrow window around base so duplicates happen often
            seq = ($urandom_range(0, 3) == 0) ? SEQ_W'($urandom)
                                              : base + SEQ_W'($urandom_range(0, 23));
            case ($urandom_range(0, 3))
               0:       ack = SEQ_W'($urandom);
               1:       ack = seq;
               2:       ack = seq + 8'd1;
               default: ack = base;
            endcase
            send_request(ACT_INSERT, seq, ack, HANDLE_W'($urandom));
         end else begin
            send_request(ACT_POP, SEQ_W'($urandom), SEQ_W'($urandom),
                         HANDLE_W'($urandom));
         end
      end
   endtask

   // Receiver holds off while requests keep coming, so the input stalls
   task automatic test_receiver_hold;
      int i;
      rsp_hold_len = HOLD_LEN;
      no_gaps      = 1'b1;
      for (i = 0; i < 40; i++)
         send_request($urandom_range(0, 4) == 0 ? ACT_POP : ACT_INSERT,
                      SEQ_W'($urandom), SEQ_W'($urandom), HANDLE_W'($urandom));
      no_gaps = 1'b0;
   endtask

   // Back-to-back traffic with no idle cycles on either side
   task automatic test_back_to_back;
      no_gaps = 1'b1;
      test_random_mix(80);
      no_gaps = 1'b0;
   endtask

   // Main sequence
   initial begin
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_INSERT;
      req_ch.seq_in    = '0;
      req_ch.last_ack  = '0;
      req_ch.handle_in = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_fill_and_drain();
      test_random_mix(440);
      test_receiver_hold();
      test_back_to_back();

      req_ch.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_rsp_q.size() != 0)
         report_mismatch("responses missing", 0, pending_rsp_q.size());

      $display("Sent %0d requests, checked %0d responses", sent_count, checked_count);
      $display("Status mix: ok %0d, duplicate %0d, full %0d, empty %0d",
               status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
               status_seen[ST_EMPTY]);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_NS);
      $display("Timeout after %0d ns", LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
